@@ hw/rtl/psci_pkg.sv @@
// Package for the pedestal-subtracted charge integrator.
// Holds payload, event record and configuration types, widths and codes.
// Used by every module of the block; depends on nothing.
`default_nettype none

package psci_pkg;

   localparam int MAX_CELLS   = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int TIME_W      = 20;
   localparam int WIN_W       = 16;
   localparam int CNT_W       = $clog2(MAX_CELLS + 1);
   localparam int SUM_W       = SAMPLE_BITS + CNT_W;
   localparam int PROD_W      = SUM_W + CNT_W + 1;
   localparam int DIFF_W      = PROD_W + 1;
   localparam int NUM_W       = DIFF_W - 1 + 4;
   localparam int STEP_W      = $clog2(NUM_W);
   localparam int CHARGE_W    = 32;
   localparam int OUT_CNT_W   = 11;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PED_END    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_BEFORE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_AFTER  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_PEDESTAL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_TRIGGER  = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic [TIME_W-1:0]             sample_time;
      logic                          is_trigger_cell;
      logic                          end_of_event;
   } req_type;

   typedef struct packed {
      logic signed [CHARGE_W-1:0] charge;
      logic [OUT_CNT_W-1:0]       window_samples;
      logic [OUT_CNT_W-1:0]       pedestal_samples;
      logic [STATUS_W-1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] ped_end;
      logic [WIN_W-1:0]  win_before;
      logic [WIN_W-1:0]  win_after;
   } cfg_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] wsum;
      logic [CNT_W-1:0]        wcnt;
      logic signed [SUM_W-1:0] psum;
      logic [CNT_W-1:0]        pcnt;
      logic                    trig_seen;
   } event_type;

endpackage

`default_nettype wire

@@ hw/rtl/psci_front.sv @@
// Front end: takes samples, accumulates pedestal and window sums per event.
// Emits one event record at end of event. Depends on psci_pkg.
`default_nettype none

module psci_front (
   input  wire                  clock,
   input  wire                  reset,
   input  psci_pkg::cfg_type    cfg,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  psci_pkg::req_type    in_data,
   input  wire                  q_full,
   output logic                 push,
   output psci_pkg::event_type  push_data
);
   import psci_pkg::*;

   logic signed [SUM_W-1:0] ped_sum_ff, ped_sum_in;
   logic [CNT_W-1:0]        ped_cnt_ff, ped_cnt_in;
   logic                    ped_closed_ff, ped_closed_in;
   logic signed [SUM_W-1:0] win_sum_ff, win_sum_in;
   logic [CNT_W-1:0]        win_cnt_ff, win_cnt_in;
   logic                    trig_seen_ff, trig_seen_in;
   logic [TIME_W-1:0]       trig_time_ff, trig_time_in;
   logic                    win_closed_ff, win_closed_in;

   logic signed [SUM_W-1:0] sample_ext;
   logic [TIME_W:0]         t_ext, lo_sum, hi;
   logic                    ped_in_range, ped_add, win_active, in_win, win_add, accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   always_comb begin
      sample_ext   = {{(SUM_W-SAMPLE_BITS){in_data.sample_value[SAMPLE_BITS-1]}},
                      in_data.sample_value};
      t_ext        = {1'b0, in_data.sample_time};
      ped_in_range = in_data.sample_time <= cfg.ped_end;
      ped_add      = !ped_closed_ff && ped_in_range && (ped_cnt_ff < CNT_W'(MAX_CELLS));
      ped_sum_in   = ped_add ? ped_sum_ff + sample_ext : ped_sum_ff;
      ped_cnt_in   = ped_add ? ped_cnt_ff + 1'b1 : ped_cnt_ff;
      ped_closed_in = ped_closed_ff || !ped_in_range;

      trig_seen_in = trig_seen_ff || in_data.is_trigger_cell;
      trig_time_in = (!trig_seen_ff && in_data.is_trigger_cell) ?
                     in_data.sample_time : trig_time_ff;

      win_active = trig_seen_in && !win_closed_ff;
      lo_sum     = t_ext + {{(TIME_W+1-WIN_W){1'b0}}, cfg.win_before};
      hi         = {1'b0, trig_time_in} + {{(TIME_W+1-WIN_W){1'b0}}, cfg.win_after};
      in_win     = (lo_sum > {1'b0, trig_time_in}) && (t_ext < hi);
      win_add    = win_active && in_win && (win_cnt_ff < CNT_W'(MAX_CELLS));
      win_sum_in = win_add ? win_sum_ff + sample_ext : win_sum_ff;
      win_cnt_in = win_add ? win_cnt_ff + 1'b1 : win_cnt_ff;
      win_closed_in = win_closed_ff || (win_active && !in_win && (t_ext > hi));

      push                = accept && in_data.end_of_event;
      push_data.wsum      = win_sum_in;
      push_data.wcnt      = win_cnt_in;
      push_data.psum      = ped_sum_in;
      push_data.pcnt      = ped_cnt_in;
      push_data.trig_seen = trig_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         ped_sum_ff    <= '0;
         ped_cnt_ff    <= '0;
         ped_closed_ff <= 1'b0;
         win_sum_ff    <= '0;
         win_cnt_ff    <= '0;
         trig_seen_ff  <= 1'b0;
         trig_time_ff  <= '0;
         win_closed_ff <= 1'b0;
      end else if (accept) begin
         ped_sum_ff    <= ped_sum_in;
         ped_cnt_ff    <= ped_cnt_in;
         ped_closed_ff <= ped_closed_in;
         win_sum_ff    <= win_sum_in;
         win_cnt_ff    <= win_cnt_in;
         trig_seen_ff  <= trig_seen_in;
         trig_time_ff  <= trig_time_in;
         win_closed_ff <= win_closed_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/psci_queue.sv @@
// Short queue of event records between front end and back end.
// Depends on psci_pkg.
`default_nettype none

module psci_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  psci_pkg::event_type  push_data,
   output logic                 full,
   input  wire                  pop,
   output logic                 not_empty,
   output psci_pkg::event_type  pop_data
);
   import psci_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   event_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;

   assign full      = fill_ff == FILL_W'(QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/psci_back.sv @@
// Back end: pedestal subtraction with an iterative divider and result register.
// Takes event records from psci_queue. Depends on psci_pkg.
`default_nettype none

module psci_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_not_empty,
   input  psci_pkg::event_type  q_data,
   output logic                 pop,
   output logic                 out_valid,
   input  wire                  out_ready,
   output psci_pkg::rsp_type    out_data
);
   import psci_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_SUB  = 6'b000100,
      ST_ABS  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   event_type                rec_ff;
   logic [CNT_W-1:0]         div_ff;
   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic                     neg_ff;
   logic [NUM_W-1:0]         quo_ff;
   logic [CNT_W-1:0]         rem_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     out_valid_ff;
   rsp_type                  out_data_ff, result;

   logic [DIFF_W-1:0]        diff_mag;
   logic [CNT_W:0]           trial, trial_sub;
   logic                     ge;
   logic                     out_free;

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_free  = !out_valid_ff || out_ready;
   assign pop       = (state_ff == ST_IDLE) && q_not_empty;

   always_comb begin
      diff_mag  = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
      trial     = {rem_ff, quo_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, div_ff};
      ge        = trial >= {1'b0, div_ff};
   end

   always_comb begin
      if (neg_ff) begin
         if (quo_ff > NUM_W'(64'h8000_0000)) begin
            result.charge = {1'b1, {(CHARGE_W-1){1'b0}}};
         end else begin
            result.charge = -$signed(quo_ff[CHARGE_W-1:0]);
         end
      end else begin
         if (quo_ff > NUM_W'(64'h7FFF_FFFF)) begin
            result.charge = {1'b0, {(CHARGE_W-1){1'b1}}};
         end else begin
            result.charge = $signed(quo_ff[CHARGE_W-1:0]);
         end
      end
      result.window_samples   = OUT_CNT_W'(rec_ff.wcnt);
      result.pedestal_samples = OUT_CNT_W'(rec_ff.pcnt);
      if (!rec_ff.trig_seen) begin
         result.status = STATUS_NO_TRIGGER;
      end else if (rec_ff.pcnt == '0) begin
         result.status = STATUS_NO_PEDESTAL;
      end else begin
         result.status = STATUS_OK;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_SUB;
         ST_SUB: state_in = ST_ABS;
         ST_ABS: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            rec_ff <= q_data;
            div_ff <= (q_data.pcnt == '0) ? CNT_W'(1) : q_data.pcnt;
         end
         ST_MUL: begin
            prod_a_ff <= rec_ff.wsum * $signed({1'b0, div_ff});
            prod_b_ff <= $signed({1'b0, rec_ff.wcnt}) * rec_ff.psum;
         end
         ST_SUB: begin
            diff_ff <= DIFF_W'(prod_a_ff) - DIFF_W'(prod_b_ff);
         end
         ST_ABS: begin
            neg_ff  <= diff_ff[DIFF_W-1];
            quo_ff  <= {diff_mag[DIFF_W-2:0], 4'b0000};
            rem_ff  <= '0;
            step_ff <= '0;
         end
         ST_DIV: begin
            rem_ff  <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_ff  <= {quo_ff[NUM_W-2:0], ge};
            step_ff <= step_ff + 1'b1;
         end
         default: begin
         end
      endcase
      if (state_ff == ST_FIN && out_free) begin
         out_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FIN && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/pedestal_subtracted_charge_integrator_unit.sv @@
// Top level of the pedestal-subtracted charge integrator.
// Instantiates psci_front, psci_queue and psci_back; depends on psci_pkg.
//
//   port group   direction   handshake            payload
//   req_*        in          req_valid/req_ready  psci_pkg::req_type
//   rsp_*        out         rsp_valid/rsp_ready  psci_pkg::rsp_type
//   csr_*        in          csr_wr_en            csr_index, csr_wdata
//
// Samples are taken one per cycle while the event queue has room.
// Each end of event takes the back end through multiply, subtract,
// magnitude, then a 43-step one-bit-per-cycle divider and a result load.
// The two-entry event queue stalls sample intake only when full.
// Synchronous active-high reset clears control state and front-end sums.
`default_nettype none

module pedestal_subtracted_charge_integrator_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  psci_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output psci_pkg::rsp_type                   rsp_data,
   input  wire                                 csr_wr_en,
   input  wire [psci_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [psci_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import psci_pkg::*;

   cfg_type   cfg_ff;
   event_type push_data, pop_data;
   logic      push, pop, q_full, q_not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ped_end    <= TIME_W'(80);
         cfg_ff.win_before <= WIN_W'(800);
         cfg_ff.win_after  <= WIN_W'(2880);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PED_END:    cfg_ff.ped_end    <= csr_wdata[TIME_W-1:0];
            CSR_WIN_BEFORE: cfg_ff.win_before <= csr_wdata[WIN_W-1:0];
            CSR_WIN_AFTER:  cfg_ff.win_after  <= csr_wdata[WIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   psci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   psci_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .pop_data  (pop_data)
   );

   psci_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (pop_data),
      .pop         (pop),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_data    (rsp_data)
   );

   a_no_trigger_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_NO_TRIGGER |->
         rsp_data.charge == '0 && rsp_data.window_samples == '0)
      else $error("no-trigger result carries window charge");

   a_pedestal_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.status == STATUS_NO_PEDESTAL) == (rsp_data.pedestal_samples == '0)) ||
         rsp_data.status == STATUS_NO_TRIGGER)
      else $error("status disagrees with pedestal count");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.window_samples <= OUT_CNT_W'(MAX_CELLS) &&
                    rsp_data.pedestal_samples <= OUT_CNT_W'(MAX_CELLS))
      else $error("sample count beyond cell limit");

   a_pop_only_filled: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_not_empty)
      else $error("event queue read while empty");

endmodule

`default_nettype wire
